// ===== hdl/vgts_pkg.sv =====
package vgts_pkg;

	// operand width of the shared multiplier (signed)
	localparam int MUL_W = 33;
	localparam int PROD_W = 2 * MUL_W;

	// value returned by a rejected read or sample
	localparam logic [31:0] MOST_NEG = 32'h8000_0000;

	// item kinds carried in the input tuser
	typedef enum logic [2:0] {
		KIND_WR_IDX = 3'd0,
		KIND_RD_IDX = 3'd1,
		KIND_WR_CRD = 3'd2,
		KIND_RD_CRD = 3'd3,
		KIND_SAMPLE = 3'd4,
		KIND_CLEAR  = 3'd5
	} kind_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_INV_X    = 3'd3,
		REG_INV_Y    = 3'd4,
		REG_INV_Z    = 3'd5
	} reg_idx_t;

endpackage

// ===== hdl/vgts_mul.sv =====
module vgts_mul (
	input  logic                                   clk,
	input  logic signed [vgts_pkg::MUL_W-1:0]      a,
	input  logic signed [vgts_pkg::MUL_W-1:0]      b,
	output logic signed [vgts_pkg::PROD_W-1:0]     p_s1
);

	// shared signed multiplier, one register stage
	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

endmodule

// ===== hdl/volume_grid_trilinear_sampler_unit.sv =====
// Trilinear sampler over a RES_X x RES_Y x RES_Z grid of signed Q16.16 words held
// in one single-port memory (cell i,j,k at i*RES_Y*RES_Z + j*RES_Z + k). One word
// is taken at a time; s_tready is low until its result is handed to the output
// register. A single 33x33 multiplier, one result per cycle, does the three axis
// mappings and all seven lerps, and the memory gives one cell per cycle. A sample
// does eight corner reads and seven lerps, in turn; a clear writes every cell,
// one cell per cycle. A finished result waits while the output register is full.
// Cells are undefined until written or cleared.
module volume_grid_trilinear_sampler_unit #(
	parameter int RES_X = 32,
	parameter int RES_Y = 32,
	parameter int RES_Z = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// cell_i, cell_j, cell_k, pos_x, pos_y, pos_z, value_in
	input  logic [151:0] s_tdata,
	// kind
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// value_out
	output logic [31:0]  m_tdata,
	// ok
	output logic [0:0]   m_tuser
);

	localparam int CELLS = RES_X * RES_Y * RES_Z;
	localparam int AW = $clog2(CELLS);
	localparam int YZ = RES_Y * RES_Z;
	localparam int MW = vgts_pkg::MUL_W;
	localparam int PW = vgts_pkg::PROD_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAP,
		ST_DEC,
		ST_RD,
		ST_SRD,
		ST_SRA,
		ST_LZ,
		ST_LY,
		ST_LX,
		ST_CLR,
		ST_FIN
	} state_t;

	state_t state_q;

	// configuration
	logic [31:0] org_q [3];
	logic [31:0] inv_q [3];

	// captured word
	vgts_pkg::kind_t kind_q;
	logic [7:0]  cidx_q [3];
	logic [31:0] pos_q [3];
	logic [31:0] val_q;

	// mapping results
	logic [1:0]  map_step_q;
	logic [63:0] prod_q [3];
	logic        neg_q [3];

	// sample neighbors and weights
	logic [7:0]  lo_q [3];
	logic [7:0]  hi_q [3];
	logic [15:0] t_q [3];
	logic [2:0]  crn_q;
	logic [31:0] va_q;
	logic [31:0] z0_q;
	logic [31:0] y0_q;
	logic [31:0] lerp_a_q;

	logic [AW-1:0] clr_cnt_q;

	logic [31:0] res_val_q;
	logic        res_ok_q;
	logic        out_valid_q;
	logic [31:0] out_val_q;
	logic        out_ok_q;

	// memory
	logic [31:0]   mem [CELLS];
	logic [31:0]   rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_addr;

	// shared multiplier
	logic signed [MW-1:0] mul_a;
	logic signed [MW-1:0] mul_b;
	logic signed [PW-1:0] mul_p;

	logic signed [32:0] d_ax [3];
	logic               dneg [3];
	logic [31:0]        idx_ax [3];
	logic               crd_ok [3];
	logic               smp_ok [3];
	logic               idx_ok;
	logic               crd_in;
	logic               smp_in;
	logic [31:0]        op_a;
	logic [31:0]        op_b;
	logic [15:0]        op_t;
	logic [33:0]        lsum;
	logic [31:0]        lres;
	logic               out_free;

	// grid resolution along one axis
	function automatic int res_of(input int ax);
		case (ax)
			0: return RES_X;
			1: return RES_Y;
			default: return RES_Z;
		endcase
	endfunction

	function automatic logic [AW-1:0] cell_addr(input logic [7:0] i, input logic [7:0] j,
			input logic [7:0] k);
		logic [31:0] a;
		a = 32'(i) * 32'(YZ) + 32'(j) * 32'(RES_Z) + 32'(k);
		return a[AW-1:0];
	endfunction

	vgts_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (mul_p)
	);

	// per-axis offset and bound checks
	always_comb begin
		for (int ax = 0; ax < 3; ax++) begin
			d_ax[ax] = $signed({pos_q[ax][31], pos_q[ax]}) - $signed({org_q[ax][31], org_q[ax]});
			dneg[ax] = d_ax[ax][32];
			idx_ax[ax] = prod_q[ax][63:32];
			crd_ok[ax] = !neg_q[ax] && (idx_ax[ax] < 32'(res_of(ax)));
			smp_ok[ax] = !neg_q[ax] && ((idx_ax[ax] < 32'(res_of(ax)))
				|| (idx_ax[ax] == 32'(res_of(ax)) && prod_q[ax][31:0] == 32'd0));
		end
		idx_ok = (32'(cidx_q[0]) < 32'(RES_X)) && (32'(cidx_q[1]) < 32'(RES_Y))
			&& (32'(cidx_q[2]) < 32'(RES_Z));
		crd_in = crd_ok[0] && crd_ok[1] && crd_ok[2];
		smp_in = smp_ok[0] && smp_ok[1] && smp_ok[2];
	end

	// multiplier operands: axis mapping or lerp difference times weight
	always_comb begin
		op_a = va_q;
		op_b = rdata_q;
		op_t = t_q[2];
		case (state_q)
			ST_LZ: begin
				op_a = z0_q;
				op_b = lres;
				op_t = t_q[1];
			end
			ST_LY: begin
				op_a = y0_q;
				op_b = lres;
				op_t = t_q[0];
			end
			default: begin
				op_a = va_q;
				op_b = rdata_q;
				op_t = t_q[2];
			end
		endcase
		if (state_q == ST_MAP && map_step_q != 2'd3) begin
			mul_a = dneg[map_step_q] ? '0 : $signed({1'b0, d_ax[map_step_q][31:0]});
			mul_b = $signed({1'b0, inv_q[map_step_q]});
		end else begin
			mul_a = $signed({op_b[31], op_b}) - $signed({op_a[31], op_a});
			mul_b = $signed({17'd0, op_t});
		end
	end

	// lerp sum: a + ((b - a) * t) >>> 16
	assign lsum = $signed({lerp_a_q[31], lerp_a_q[31], lerp_a_q}) + $signed(mul_p[49:16]);
	assign lres = lsum[31:0];

	// memory address and write enable
	always_comb begin
		mem_we = 1'b0;
		mem_addr = clr_cnt_q;
		case (state_q)
			ST_DEC: begin
				if (kind_q == vgts_pkg::KIND_WR_CRD || kind_q == vgts_pkg::KIND_RD_CRD) begin
					mem_addr = cell_addr(idx_ax[0][7:0], idx_ax[1][7:0], idx_ax[2][7:0]);
					mem_we = (kind_q == vgts_pkg::KIND_WR_CRD) && crd_in;
				end else begin
					mem_addr = cell_addr(cidx_q[0], cidx_q[1], cidx_q[2]);
					mem_we = (kind_q == vgts_pkg::KIND_WR_IDX) && idx_ok;
				end
			end
			ST_SRD: begin
				mem_addr = cell_addr(crn_q[2] ? hi_q[0] : lo_q[0], crn_q[1] ? hi_q[1] : lo_q[1],
					crn_q[0] ? hi_q[2] : lo_q[2]);
			end
			ST_CLR: begin
				mem_we = 1'b1;
				mem_addr = clr_cnt_q;
			end
			default: begin
				mem_we = 1'b0;
				mem_addr = clr_cnt_q;
			end
		endcase
	end

	// cell memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= val_q;
		end
		rdata_q <= mem[mem_addr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int ax = 0; ax < 3; ax++) begin
				org_q[ax] <= 32'd0;
				inv_q[ax] <= 32'h0001_0000;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				vgts_pkg::REG_ORIGIN_X: org_q[0] <= cfg_data;
				vgts_pkg::REG_ORIGIN_Y: org_q[1] <= cfg_data;
				vgts_pkg::REG_ORIGIN_Z: org_q[2] <= cfg_data;
				vgts_pkg::REG_INV_X:    inv_q[0] <= cfg_data;
				vgts_pkg::REG_INV_Y:    inv_q[1] <= cfg_data;
				vgts_pkg::REG_INV_Z:    inv_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || m_tready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			map_step_q <= 2'd0;
			crn_q <= 3'd0;
			clr_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output word taken and nothing new to load
			if (out_valid_q && m_tready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						kind_q <= vgts_pkg::kind_t'(s_tuser);
						cidx_q[0] <= s_tdata[7:0];
						cidx_q[1] <= s_tdata[15:8];
						cidx_q[2] <= s_tdata[23:16];
						pos_q[0] <= s_tdata[55:24];
						pos_q[1] <= s_tdata[87:56];
						pos_q[2] <= s_tdata[119:88];
						val_q <= s_tdata[151:120];
						map_step_q <= 2'd0;
						state_q <= ST_MAP;
					end
				end
				ST_MAP: begin
					// issue one axis, collect the previous one
					if (map_step_q != 2'd3) begin
						neg_q[map_step_q] <= dneg[map_step_q] && (inv_q[map_step_q] != 32'd0);
					end
					if (map_step_q != 2'd0) begin
						prod_q[map_step_q - 2'd1] <= mul_p[63:0];
					end
					map_step_q <= map_step_q + 2'd1;
					if (map_step_q == 2'd3) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					res_val_q <= 32'd0;
					res_ok_q <= 1'b0;
					state_q <= ST_FIN;
					for (int ax = 0; ax < 3; ax++) begin
						lo_q[ax] <= (idx_ax[ax] > 32'(res_of(ax) - 1)) ? 8'(res_of(ax) - 1)
							: idx_ax[ax][7:0];
						hi_q[ax] <= (idx_ax[ax] >= 32'(res_of(ax) - 1)) ? 8'(res_of(ax) - 1)
							: idx_ax[ax][7:0] + 8'd1;
						t_q[ax] <= prod_q[ax][31:16];
					end
					case (kind_q)
						vgts_pkg::KIND_WR_IDX: res_ok_q <= idx_ok;
						vgts_pkg::KIND_WR_CRD: res_ok_q <= crd_in;
						vgts_pkg::KIND_RD_IDX: begin
							res_val_q <= vgts_pkg::MOST_NEG;
							if (idx_ok) begin
								state_q <= ST_RD;
							end
						end
						vgts_pkg::KIND_RD_CRD: begin
							res_val_q <= vgts_pkg::MOST_NEG;
							if (crd_in) begin
								state_q <= ST_RD;
							end
						end
						vgts_pkg::KIND_SAMPLE: begin
							res_val_q <= vgts_pkg::MOST_NEG;
							crn_q <= 3'd0;
							if (smp_in) begin
								state_q <= ST_SRD;
							end
						end
						vgts_pkg::KIND_CLEAR: begin
							clr_cnt_q <= '0;
							state_q <= ST_CLR;
						end
						default: ;
					endcase
				end
				ST_RD: begin
					res_val_q <= rdata_q;
					res_ok_q <= 1'b1;
					state_q <= ST_FIN;
				end
				ST_SRD: begin
					state_q <= ST_SRA;
				end
				ST_SRA: begin
					// even corner waits for its z partner
					if (!crn_q[0]) begin
						va_q <= rdata_q;
						crn_q <= crn_q + 3'd1;
						state_q <= ST_SRD;
					end else begin
						lerp_a_q <= va_q;
						state_q <= ST_LZ;
					end
				end
				ST_LZ: begin
					if (!crn_q[1]) begin
						z0_q <= lres;
						crn_q <= crn_q + 3'd1;
						state_q <= ST_SRD;
					end else begin
						lerp_a_q <= z0_q;
						state_q <= ST_LY;
					end
				end
				ST_LY: begin
					if (!crn_q[2]) begin
						y0_q <= lres;
						crn_q <= crn_q + 3'd1;
						state_q <= ST_SRD;
					end else begin
						lerp_a_q <= y0_q;
						state_q <= ST_LX;
					end
				end
				ST_LX: begin
					res_val_q <= lres;
					res_ok_q <= 1'b1;
					state_q <= ST_FIN;
				end
				ST_CLR: begin
					if (clr_cnt_q == LAST_ADDR) begin
						clr_cnt_q <= '0;
						res_ok_q <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						clr_cnt_q <= clr_cnt_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_val_q <= res_val_q;
						out_ok_q <= res_ok_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_val_q;
	assign m_tuser = out_ok_q;

	// clear cursor rests at zero outside a clear
	a_cursor_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_CLR |-> clr_cnt_q == '0) else $error("clear cursor not parked");

	// clear sweep advances one cell a cycle
	a_cursor_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLR && clr_cnt_q != LAST_ADDR |=> clr_cnt_q == $past(clr_cnt_q) + 1'b1)
		else $error("clear cursor skipped");

	// an accepted word starts the axis mapping
	a_accept_map: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_MAP && map_step_q == 2'd0)
		else $error("mapping not started");

	// a finished result lands in the free output register
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && out_free |=> out_valid_q && state_q == ST_IDLE)
		else $error("result not delivered");

endmodule
